[src/box_mean_filter_3x3_macros.svh]
// assertion helpers for the box mean filter
`ifndef BOX_MEAN_FILTER_3X3_MACROS_SVH
`define BOX_MEAN_FILTER_3X3_MACROS_SVH

// concurrent assertion on an explicit clock and reset
`define BMF_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// concurrent assertion on the block clock and reset
`define BMF_ASSERT(lbl, prop, msg) \
  `BMF_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

[src/bmf_pkg.sv]
`timescale 1ns / 1ps
package bmf_pkg;

  localparam int MAX_SIZE = 1024;
  localparam int AW       = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int PIX_W    = 8;
  localparam int POS_W    = 10;
  localparam int CFG_W    = 11;
  localparam int SUM_W    = 12;
  localparam int CNT_W    = 4;
  localparam int ADDR_W   = 3;
  localparam int DATA_W   = 32;

  // register index of image_size
  localparam logic [ADDR_W-3:0] REG_IMAGE_SIZE = '0;
  localparam logic [CFG_W-1:0]  IMAGE_SIZE_RST = CFG_W'(8);

  // reciprocals for divide by 3 and by 9, 16 fraction bits
  localparam logic [14:0] RECIP_3 = 15'd21846;
  localparam logic [14:0] RECIP_9 = 15'd7282;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [AW-1:0]    pos_t;

  // floor(sum / cnt) for cnt in 1, 2, 3, 4, 6, 9
  function automatic pix_t bmf_mean(input logic [SUM_W-1:0] sum, input logic [CNT_W-1:0] cnt);
    logic [14:0]       m;
    logic [SUM_W+14:0] p;
    logic [SUM_W-1:0]  q;
    m = (cnt == CNT_W'(9)) ? RECIP_9 : RECIP_3;
    p = {15'd0, sum} * {{SUM_W{1'b0}}, m};
    case (cnt)
      CNT_W'(1): q = sum;
      CNT_W'(2): q = sum >> 1;
      CNT_W'(3): q = SUM_W'(p >> 16);
      CNT_W'(4): q = sum >> 2;
      CNT_W'(6): q = SUM_W'(p >> 17);
      CNT_W'(9): q = SUM_W'(p >> 16);
      default:   q = sum;
    endcase
    return q[PIX_W-1:0];
  endfunction

endpackage

[src/bmf_ram.sv]
`timescale 1ns / 1ps
module bmf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/box_mean_filter_3x3.sv]
`timescale 1ns / 1ps
// 3x3 box mean filter over a square image streamed in raster order.
// input channel: in_valid_i / in_ready_o move one pixel beat, row by row.
// output channel: out_valid_o / out_ready_i move one result beat holding the
// floor mean of the in-image neighbours, its row and column, and frame_last_o
// on the result for the bottom-right pixel.
// config: apb-style port, image_size at byte address 0, pready always high;
// a write restarts the frame (counters and window cleared, lines kept).
// rate: a pixel beat is followed by the S_READ state and then S_EMIT, which
// loads one result per cycle while the output register is free (up to 4 on
// the final row) and takes the next pixel with the last of them; the pace is
// set by the single-port line ram, read in the accept cycle and written back
// in the next one. a result is loaded into the output register in S_EMIT,
// after the line ram read and the window shift of S_READ for its pixel.
// stall: a result waits in the output register while out_ready_i is low;
// the next pixel is taken as soon as the last pending result is loaded.
// reset: image_size is 8, frame position 0, window zero; the line ram has
// no clearing pass, its unwritten entries only feed out-of-image neighbours.
module box_mean_filter_3x3
  import bmf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // pixel beats
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [PIX_W-1:0]  pixel_i,
  // result beats
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [PIX_W-1:0]  smoothed_o,
  output logic [POS_W-1:0]  out_row_o,
  output logic [POS_W-1:0]  out_col_o,
  output logic              frame_last_o,
  // config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [CFG_W-1:0] image_size_q, image_size_d;
  pos_t             row_q, row_d, col_q, col_d;   // position of the next pixel
  pos_t             cur_i_q, cur_i_d, cur_j_q, cur_j_d;  // pixel in flight
  pix_t             px_q, px_d;
  logic [3:0]       rem_q, rem_d;                 // results still to emit
  pix_t             win_q [3][3];
  pix_t             win_d [3][3];

  logic             out_valid_q, out_valid_d;
  pix_t             smoothed_q, smoothed_d;
  logic [POS_W-1:0] out_row_q, out_row_d, out_col_q, out_col_d;
  logic             frame_last_q, frame_last_d;

  logic             cfg_wr;
  pos_t             nm1;        // effective size minus one
  logic             in_acc;
  logic             out_free;
  logic             last_go;

  // line ram: {two rows above, row above} per column
  logic             ram_we, ram_re;
  pos_t             ram_addr;
  logic [2*PIX_W-1:0] ram_wdata, ram_rdata;

  // candidate selection
  logic [1:0]       sel_k;
  logic             emit_go;
  logic [2:0]       rv, cv;
  logic [1:0]       rn, cn;
  logic [CNT_W-1:0] cnt;
  logic [SUM_W-1:0] sum;
  pos_t             cand_r, cand_c;
  logic             i_ge1, i_ge2, j_ge1, j_ge2;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[ADDR_W-1:2] == REG_IMAGE_SIZE);
  assign prdata = (paddr[ADDR_W-1:2] == REG_IMAGE_SIZE) ?
                  {{(DATA_W-CFG_W){1'b0}}, image_size_q} : '0;

  // a size of zero acts as one, anything above the line depth is clamped
  always_comb begin
    if (image_size_q == '0) begin
      nm1 = '0;
    end else if (32'(image_size_q) > MAX_SIZE) begin
      nm1 = AW'(MAX_SIZE - 1);
    end else begin
      nm1 = AW'(image_size_q - CFG_W'(1));
    end
  end

  assign out_free = !out_valid_q || out_ready_i;
  assign emit_go  = (state_q == S_EMIT) && (rem_q != '0) && out_free;
  // the last pending result goes out this cycle, or none is pending
  assign last_go  = (rem_q == '0) || ($onehot(rem_q) && out_free);
  assign in_ready_o = (state_q == S_IDLE) || ((state_q == S_EMIT) && last_go);
  assign in_acc   = in_valid_i && in_ready_o;

  // read in the accept cycle, write back the shifted column in the next one
  assign ram_re    = in_acc;
  assign ram_we    = (state_q == S_READ);
  assign ram_addr  = ram_we ? cur_j_q : col_q;
  assign ram_wdata = {ram_rdata[PIX_W-1:0], px_q};

  bmf_ram #(
    .WIDTH(2 * PIX_W),
    .DEPTH(MAX_SIZE)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign i_ge1 = (cur_i_q != '0);
  assign i_ge2 = (cur_i_q > AW'(1));
  assign j_ge1 = (cur_j_q != '0);
  assign j_ge2 = (cur_j_q > AW'(1));

  // lowest pending candidate: bit 1 of the code picks row i over row i-1,
  // bit 0 picks column j over column j-1
  always_comb begin
    if (rem_q[0]) begin
      sel_k = 2'd0;
    end else if (rem_q[1]) begin
      sel_k = 2'd1;
    end else if (rem_q[2]) begin
      sel_k = 2'd2;
    end else begin
      sel_k = 2'd3;
    end
  end

  // window rows and columns that hold in-image neighbours of the candidate
  always_comb begin
    rv = sel_k[1] ? {1'b1, i_ge1, 1'b0} : {1'b1, 1'b1, i_ge2};
    cv = sel_k[0] ? {1'b1, j_ge1, 1'b0} : {1'b1, 1'b1, j_ge2};
    rn = 2'($countones(rv));
    cn = 2'($countones(cv));
    cnt = {2'b00, rn} * {2'b00, cn};
    sum = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (rv[r] && cv[c]) begin
          sum = sum + SUM_W'(win_q[r][c]);
        end
      end
    end
    cand_r = sel_k[1] ? cur_i_q : cur_i_q - AW'(1);
    cand_c = sel_k[0] ? cur_j_q : cur_j_q - AW'(1);
  end

  always_comb begin
    state_d      = state_q;
    image_size_d = image_size_q;
    row_d        = row_q;
    col_d        = col_q;
    cur_i_d      = cur_i_q;
    cur_j_d      = cur_j_q;
    px_d         = px_q;
    rem_d        = rem_q;
    win_d        = win_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    smoothed_d   = smoothed_q;
    out_row_d    = out_row_q;
    out_col_d    = out_col_q;
    frame_last_d = frame_last_q;

    case (state_q)
      S_IDLE: begin
      end
      S_READ: begin
        // shift the window left and bring in the new column
        for (int k = 0; k < 3; k++) begin
          win_d[k][0] = win_q[k][1];
          win_d[k][1] = win_q[k][2];
        end
        win_d[0][2] = ram_rdata[2*PIX_W-1:PIX_W];
        win_d[1][2] = ram_rdata[PIX_W-1:0];
        win_d[2][2] = px_q;
        rem_d[0] = i_ge1 && j_ge1;
        rem_d[1] = i_ge1 && (cur_j_q == nm1);
        rem_d[2] = (cur_i_q == nm1) && j_ge1;
        rem_d[3] = (cur_i_q == nm1) && (cur_j_q == nm1);
        if (cur_j_q == nm1) begin
          col_d = '0;
          row_d = (cur_i_q == nm1) ? '0 : cur_i_q + AW'(1);
        end else begin
          col_d = cur_j_q + AW'(1);
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (emit_go) begin
          out_valid_d  = 1'b1;
          smoothed_d   = bmf_mean(sum, cnt);
          out_row_d    = POS_W'(cand_r);
          out_col_d    = POS_W'(cand_c);
          frame_last_d = (sel_k == 2'd3) && (cur_i_q == nm1) && (cur_j_q == nm1);
          rem_d[sel_k] = 1'b0;
        end
        if (last_go) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (in_acc) begin
      cur_i_d = row_q;
      cur_j_d = col_q;
      px_d    = pixel_i;
      state_d = S_READ;
    end

    // a size write restarts the frame
    if (cfg_wr) begin
      image_size_d = pwdata[CFG_W-1:0];
      row_d        = '0;
      col_d        = '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_d[r][c] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      image_size_q <= IMAGE_SIZE_RST;
      row_q        <= '0;
      col_q        <= '0;
      rem_q        <= '0;
      out_valid_q  <= 1'b0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else begin
      state_q      <= state_d;
      image_size_q <= image_size_d;
      row_q        <= row_d;
      col_q        <= col_d;
      rem_q        <= rem_d;
      out_valid_q  <= out_valid_d;
      win_q        <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_i_q      <= cur_i_d;
    cur_j_q      <= cur_j_d;
    px_q         <= px_d;
    smoothed_q   <= smoothed_d;
    out_row_q    <= out_row_d;
    out_col_q    <= out_col_d;
    frame_last_q <= frame_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign smoothed_o   = smoothed_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign frame_last_o = frame_last_q;

`include "box_mean_filter_3x3_macros.svh"

  `BMF_ASSERT(a_accept_reads, in_acc |=> (state_q == S_READ), "beat did not start a read")
  `BMF_ASSERT(a_load_from_emit, $rose(out_valid_o) |-> $past(state_q == S_EMIT), "stray load")
  `BMF_ASSERT(a_one_per_cycle, emit_go |=> $onehot($past(rem_q) & ~rem_q), "bad retire")
  `BMF_ASSERT(a_last_on_diag, out_valid_o && frame_last_o |-> out_row_o == out_col_o, "bad last")

endmodule

[tb/tb_box_mean_filter_3x3.sv]
`timescale 1ns / 1ps
module tb_box_mean_filter_3x3;
  import bmf_pkg::*;

  // stall of the result side that must back up into the pixel side
  localparam int HOLD_CYCLES    = 200;
  // quiet cycles after the last expected result before touching the size
  localparam int DRAIN_CYCLES   = 8;
  // cycles without any beat or register write before giving up
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PIXELS  = 240;
  // most pixels in one random phase
  localparam int PHASE_PIXELS   = 100;

  typedef struct packed {
    pix_t             smoothed;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             frame_last;
  } mean_beat_t;

  // predicts the smoothed pixels from the accepted pixels and checks them in order
  class mean_scoreboard;
    logic [CFG_W-1:0] size_reg;
    pix_t             line_up2 [MAX_SIZE];
    pix_t             line_up1 [MAX_SIZE];
    pix_t             win [3][3];
    int               row_pos;
    int               col_pos;
    mean_beat_t       expected_q[$];
    int unsigned      errors;

    function new();
      size_reg = IMAGE_SIZE_RST;
      foreach (line_up2[k]) begin
        line_up2[k] = '0;
        line_up1[k] = '0;
      end
      restart_frame();
      errors = 0;
    endfunction

    function void restart_frame();
      win     = '{default: '0};
      row_pos = 0;
      col_pos = 0;
    endfunction

    // a size write restarts the frame, the line buffers keep their contents
    function void set_image_size(logic [CFG_W-1:0] value);
      size_reg = value;
      restart_frame();
    endfunction

    function int side();
      if (size_reg == '0) return 1;
      if (size_reg > MAX_SIZE) return MAX_SIZE;
      return int'(size_reg);
    endfunction

    // floor mean of the in-image neighbours of (r, c) with (i, j) the newest pixel
    function pix_t window_mean(int r, int c, int i, int j, int n);
      int unsigned sum;
      int unsigned cnt;
      sum = 0;
      cnt = 0;
      for (int rr = r - 1; rr <= r + 1; rr++) begin
        if (rr < 0 || rr >= n || rr > i || rr < i - 2) continue;
        for (int cc = c - 1; cc <= c + 1; cc++) begin
          if (cc < 0 || cc >= n || cc > j || cc < j - 2) continue;
          sum += win[rr - i + 2][cc - j + 2];
          cnt++;
        end
      end
      if (cnt == 0) return '0;
      return pix_t'(sum / cnt);
    endfunction

    function void note_pixel(pix_t px);
      int         n;
      int         i;
      int         j;
      mean_beat_t want;
      n = side();
      i = row_pos;
      j = col_pos;
      if (i >= n || j >= n) begin
        i = 0;
        j = 0;
      end
      for (int k = 0; k < 3; k++) begin
        win[k][0] = win[k][1];
        win[k][1] = win[k][2];
      end
      win[0][2]   = line_up2[j];
      win[1][2]   = line_up1[j];
      win[2][2]   = px;
      line_up2[j] = line_up1[j];
      line_up1[j] = px;
      // row above always completes; the final row completes together with it
      for (int r = i - 1; r <= i; r++) begin
        if (r < 0 || (r == i && i != n - 1)) continue;
        for (int c = j - 1; c <= j; c++) begin
          if (c < 0 || (c == j && j != n - 1)) continue;
          want.smoothed   = window_mean(r, c, i, j, n);
          want.row        = POS_W'(r);
          want.col        = POS_W'(c);
          want.frame_last = (r == n - 1 && c == n - 1);
          expected_q.push_back(want);
        end
      end
      j++;
      if (j >= n) begin
        j = 0;
        i++;
        if (i >= n) i = 0;
      end
      row_pos = i;
      col_pos = j;
    endfunction

    function void check_result(mean_beat_t got);
      mean_beat_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected: smoothed %0d row %0d col %0d last %0d",
                 $time, got.smoothed, got.row, got.col, got.frame_last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.smoothed !== want.smoothed) begin
        $display("%0t: smoothed at (%0d,%0d): expected %0d, actual %0d",
                 $time, want.row, want.col, want.smoothed, got.smoothed);
        errors++;
      end
      if (got.row !== want.row) begin
        $display("%0t: out_row: expected %0d, actual %0d", $time, want.row, got.row);
        errors++;
      end
      if (got.col !== want.col) begin
        $display("%0t: out_col: expected %0d, actual %0d", $time, want.col, got.col);
        errors++;
      end
      if (got.frame_last !== want.frame_last) begin
        $display("%0t: frame_last at (%0d,%0d): expected %0d, actual %0d",
                 $time, want.row, want.col, want.frame_last, got.frame_last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [PIX_W-1:0]  pixel_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [PIX_W-1:0]  smoothed_o;
  logic [POS_W-1:0]  out_row_o;
  logic [POS_W-1:0]  out_col_o;
  logic              frame_last_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  mean_scoreboard sb;
  bit             in_gaps;          // random idle cycles on the pixel side
  bit             out_stalls;       // random stall cycles on the result side
  int unsigned    hold_reqs = 0;    // bumped to ask the result side for a long stall
  int unsigned    idle_cycles = 0;

  box_mean_filter_3x3 DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .pixel_i     (pixel_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .smoothed_o  (smoothed_o),
    .out_row_o   (out_row_o),
    .out_col_o   (out_col_o),
    .frame_last_o(frame_last_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // result side: random stalls, plus one long hold-off counted here on request
  initial begin
    int unsigned holds_done;
    holds_done  = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (holds_done != hold_reqs) begin
        holds_done++;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end else if (out_stalls && $urandom_range(99) < 15) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // every result beat goes to the scoreboard, sampled with pre-edge values
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_result({smoothed_o, out_row_o, out_col_o, frame_last_o});
  end

  // watchdog: any beat or register access keeps it quiet
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)
        || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("tb_box_mean_filter_3x3: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one pixel beat; called and returns right after a falling edge
  task automatic send_pixel(input pix_t px);
    while (in_gaps && $urandom_range(99) < 15) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= px;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pixel(px);
    @(negedge clk_i);
  endtask

  // random pixels, with the extremes mixed in so sums hit their limits
  task automatic send_pixels(input int unsigned count);
    pix_t px;
    repeat (count) begin
      case ($urandom_range(9))
        0:       px = '0;
        1:       px = '1;
        default: px = pix_t'($urandom);
      endcase
      send_pixel(px);
    end
  endtask

  // drop valid, let every expected result drain, then give the block time to settle
  task automatic finish_phase();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // apb write of image_size; the bits above the register get random junk
  task automatic write_image_size(input int unsigned value);
    logic [DATA_W-1:0] word;
    word             = DATA_W'($urandom);
    word[CFG_W-1:0]  = value[CFG_W-1:0];
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_IMAGE_SIZE, 2'b00};
    pwdata  <= word;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_image_size(word[CFG_W-1:0]);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int unsigned random_pixels;
    int unsigned phase;
    int unsigned sel;
    int unsigned n;
    int unsigned eff;
    int unsigned count;
    sb         = new();
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    pixel_i    = '0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_gaps    = 1'b1;
    out_stalls = 1'b1;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset size of 8: alternating black and white, only the corner (0,0) completes
    for (int k = 0; k < 10; k++) send_pixel((k % 2) ? 8'hFF : 8'h00);
    finish_phase();

    // single pixel image: each pixel comes back as is, frame_last on every beat
    write_image_size(1);
    send_pixel(8'h00);
    send_pixel(8'hFF);
    send_pixel(8'h55);
    send_pixel(8'hAA);
    finish_phase();

    // size zero behaves as one
    write_image_size(0);
    send_pixel(8'hFF);
    send_pixel(8'h00);
    finish_phase();

    // all-white 2x2: corners only, largest four-value sum
    write_image_size(2);
    repeat (4) send_pixel(8'hFF);
    finish_phase();

    // 3x3 checkerboard: corners, edges and one full interior window
    write_image_size(3);
    for (int k = 0; k < 9; k++) send_pixel((k % 2) ? 8'h00 : 8'hFF);
    finish_phase();

    // oversize clamps to the largest side; the first row stays open, nothing completes
    write_image_size(2047);
    send_pixels(20);
    finish_phase();

    // random part: mostly whole frames at small sizes, some cut short by a size write
    random_pixels = 0;
    phase         = 0;
    while (random_pixels < RANDOM_PIXELS || phase < 5) begin
      sel = $urandom_range(19);
      if (sel == 0)     n = 0;
      else if (sel < 4) n = $urandom_range(16, 9);
      else              n = $urandom_range(8, 1);
      if (phase == 2) n = 6;
      eff = (n == 0) ? 1 : n;
      if (phase != 2 && $urandom_range(4) == 0) count = $urandom_range(eff * eff, 1);
      else                                      count = eff * eff * $urandom_range(2, 1);
      if (count > PHASE_PIXELS) count = PHASE_PIXELS;
      // one phase runs with no idling on either side
      in_gaps    = (phase != 4);
      out_stalls <= (phase != 4);
      write_image_size(n);
      // long result-side hold-off while pixels keep coming, so the input backs up
      if (phase == 2) hold_reqs <= hold_reqs + 1;
      send_pixels(count);
      finish_phase();
      random_pixels += count;
      phase++;
    end

    if (sb.errors == 0) begin
      $display("tb_box_mean_filter_3x3: PASS");
    end else begin
      $display("tb_box_mean_filter_3x3: FAIL");
    end
    $finish;
  end

endmodule
